// ===== rtl/core/jsv_pkg.sv =====
package jsv_pkg;

    typedef enum logic [4:0] {
        S_VALUE, S_ARR_FIRST, S_OBJ_FIRST, S_OBJ_KEY, S_KEY_STR, S_KEY_ESC,
        S_COLON, S_STR, S_STR_ESC, S_LIT_T, S_LIT_F, S_LIT_N,
        S_NUM_MINUS, S_NUM_INT, S_NUM_DOT, S_NUM_FRAC, S_NUM_E, S_NUM_ESIGN,
        S_NUM_EXP, S_AFTER
    } parse_state_t;

    typedef enum logic [1:0] {
        STATUS_BUSY   = 2'd0,
        STATUS_VALID  = 2'd1,
        STATUS_REJECT = 2'd2
    } status_t;

    localparam logic KIND_OBJECT = 1'b1;
    localparam logic KIND_ARRAY  = 1'b0;

    localparam logic [5:0]  DEPTH_LIMIT_RESET = 6'd32;
    localparam logic [31:0] POSITION_MAX      = 32'hFFFF_FFFF;

    // Stack control from the byte step to the kind stack.
    typedef struct packed {
        logic push;
        logic pop;
        logic kind;
    } stack_ctl_t;

    // Outcome of a byte that starts a value.
    typedef struct packed {
        logic         ok;
        parse_state_t state;
        logic         lit_start;
        logic         push;
        logic         kind;
    } value_start_t;

    function automatic logic [2:0] lit_len(parse_state_t st);
        case (st)
            S_LIT_F: lit_len = 3'd5;
            default: lit_len = 3'd4;
        endcase
    endfunction

    function automatic logic [7:0] lit_char(parse_state_t st, logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (st)
            S_LIT_T: begin
                case (idx)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            S_LIT_F: begin
                case (idx)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            S_LIT_N: begin
                case (idx)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        lit_char = ch;
    endfunction

endpackage

// ===== rtl/core/jsv_in_stage.sv =====
module jsv_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_value,
    input  logic       s_last,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte,
    output logic       in_last
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign s_ready  = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_value;
            last_reg <= s_last;
        end
    end

endmodule

// ===== rtl/core/jsv_kind_stack.sv =====
module jsv_kind_stack #(
    parameter int MAX_DEPTH = 32
) (
    input  logic                aclk,
    input  jsv_pkg::stack_ctl_t ctl,
    output logic                top_kind
);
    import jsv_pkg::*;

    // Shift stack: the top entry always sits in bit 0.
    logic [MAX_DEPTH-1:0] stack_reg;

    assign top_kind = stack_reg[0];

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            stack_reg <= (stack_reg << 1) | MAX_DEPTH'(ctl.kind);
        end else if (ctl.pop) begin
            stack_reg <= stack_reg >> 1;
        end
    end

endmodule

// ===== rtl/core/jsv_step.sv =====
module jsv_step #(
    parameter int MAX_DEPTH = 32,
    parameter int DW        = $clog2(MAX_DEPTH + 1)
) (
    input  jsv_pkg::parse_state_t cur_state,
    input  logic [2:0]            cur_lit,
    input  logic [DW-1:0]         cur_depth,
    input  logic                  cur_rejected,
    input  logic                  top_kind,
    input  logic [7:0]            byte_value,
    input  logic                  last,
    input  logic [5:0]            depth_limit,
    output jsv_pkg::parse_state_t nxt_state,
    output logic [2:0]            nxt_lit,
    output logic [DW-1:0]         nxt_depth,
    output logic                  nxt_rejected,
    output jsv_pkg::status_t      status,
    output jsv_pkg::stack_ctl_t   ctl
);
    import jsv_pkg::*;

    localparam int CW = (DW > 6) ? DW : 6;
    localparam logic [CW-1:0] MAX_D = CW'(MAX_DEPTH);

    logic          is_ws;
    logic          is_dig;
    logic          is_esc;
    logic [CW-1:0] lim_ext;
    logic [CW-1:0] eff_lim;
    logic          can_push;

    parse_state_t  st;
    parse_state_t  ns;
    logic [2:0]    nl;
    logic [DW-1:0] nd;
    logic          ok;
    logic          consumed;
    logic          push;
    logic          pop;
    logic          kind;
    logic          done;
    value_start_t  vs;

    assign is_ws  = (byte_value == 8'd32) || (byte_value inside {[8'd9:8'd13]});
    assign is_dig = byte_value inside {["0":"9"]};
    assign is_esc = byte_value inside {"\"", "\\", "/", "b", "f", "n", "r", "t"};

    assign lim_ext  = CW'(depth_limit);
    assign eff_lim  = (lim_ext < MAX_D) ? lim_ext : MAX_D;
    assign can_push = CW'(cur_depth) < eff_lim;

    // Value start, shared by top level, array slot and after a colon.
    always_comb begin
        vs = '{ok: 1'b1, state: S_VALUE, lit_start: 1'b0, push: 1'b0, kind: KIND_ARRAY};
        case (byte_value)
            "\"": vs.state = S_STR;
            "{": begin
                vs.ok    = can_push;
                vs.push  = can_push;
                vs.kind  = KIND_OBJECT;
                vs.state = S_OBJ_FIRST;
            end
            "[": begin
                vs.ok    = can_push;
                vs.push  = can_push;
                vs.kind  = KIND_ARRAY;
                vs.state = S_ARR_FIRST;
            end
            "t": begin
                vs.state     = S_LIT_T;
                vs.lit_start = 1'b1;
            end
            "f": begin
                vs.state     = S_LIT_F;
                vs.lit_start = 1'b1;
            end
            "n": begin
                vs.state     = S_LIT_N;
                vs.lit_start = 1'b1;
            end
            "-": vs.state = S_NUM_MINUS;
            default: begin
                vs.ok    = is_dig;
                vs.state = S_NUM_INT;
            end
        endcase
    end

    always_comb begin
        st       = cur_state;
        ns       = cur_state;
        nl       = cur_lit;
        nd       = cur_depth;
        ok       = 1'b1;
        consumed = 1'b1;
        push     = 1'b0;
        pop      = 1'b0;
        kind     = vs.kind;

        // Number states take the byte, reject it, or hand it on as a byte after a value.
        case (cur_state)
            S_NUM_MINUS: begin
                ok = is_dig;
                ns = S_NUM_INT;
            end
            S_NUM_INT: begin
                if (is_dig) begin
                    ns = S_NUM_INT;
                end else if (byte_value == ".") begin
                    ns = S_NUM_DOT;
                end else if (byte_value == "e" || byte_value == "E") begin
                    ns = S_NUM_E;
                end else begin
                    consumed = 1'b0;
                    st       = S_AFTER;
                end
            end
            S_NUM_DOT: begin
                ok = is_dig;
                ns = S_NUM_FRAC;
            end
            S_NUM_FRAC: begin
                if (is_dig) begin
                    ns = S_NUM_FRAC;
                end else if (byte_value == "e" || byte_value == "E") begin
                    ns = S_NUM_E;
                end else begin
                    consumed = 1'b0;
                    st       = S_AFTER;
                end
            end
            S_NUM_E: begin
                if (byte_value == "+" || byte_value == "-") begin
                    ns = S_NUM_ESIGN;
                end else begin
                    ok = is_dig;
                    ns = S_NUM_EXP;
                end
            end
            S_NUM_ESIGN: begin
                ok = is_dig;
                ns = S_NUM_EXP;
            end
            S_NUM_EXP: begin
                if (!is_dig) begin
                    consumed = 1'b0;
                    st       = S_AFTER;
                end
            end
            default: consumed = 1'b0;
        endcase

        if (!consumed) begin
            ns = st;
            case (st)
                S_VALUE: begin
                    if (!is_ws) begin
                        ok   = vs.ok;
                        ns   = vs.state;
                        push = vs.push;
                        if (vs.lit_start) nl = 3'd1;
                    end
                end
                S_ARR_FIRST: begin
                    if (byte_value == "]") begin
                        pop = 1'b1;
                        ns  = S_AFTER;
                    end else if (!is_ws) begin
                        ok   = vs.ok;
                        ns   = vs.state;
                        push = vs.push;
                        if (vs.lit_start) nl = 3'd1;
                    end
                end
                S_OBJ_FIRST: begin
                    if (byte_value == "}") begin
                        pop = 1'b1;
                        ns  = S_AFTER;
                    end else if (byte_value == "\"") begin
                        ns = S_KEY_STR;
                    end else begin
                        ok = is_ws;
                    end
                end
                S_OBJ_KEY: begin
                    if (byte_value == "\"") begin
                        ns = S_KEY_STR;
                    end else begin
                        ok = is_ws;
                    end
                end
                S_KEY_STR: begin
                    if (byte_value == "\"") begin
                        ns = S_COLON;
                    end else if (byte_value == "\\") begin
                        ns = S_KEY_ESC;
                    end
                end
                S_KEY_ESC: begin
                    ok = is_esc;
                    ns = S_KEY_STR;
                end
                S_COLON: begin
                    if (byte_value == ":") begin
                        ns = S_VALUE;
                    end else begin
                        ok = is_ws;
                    end
                end
                S_STR: begin
                    if (byte_value == "\"") begin
                        ns = S_AFTER;
                    end else if (byte_value == "\\") begin
                        ns = S_STR_ESC;
                    end
                end
                S_STR_ESC: begin
                    ok = is_esc;
                    ns = S_STR;
                end
                S_LIT_T, S_LIT_F, S_LIT_N: begin
                    if (cur_lit >= lit_len(st) || byte_value != lit_char(st, cur_lit)) begin
                        ok = 1'b0;
                    end else if (cur_lit + 3'd1 == lit_len(st)) begin
                        nl = 3'd0;
                        ns = S_AFTER;
                    end else begin
                        nl = cur_lit + 3'd1;
                    end
                end
                S_AFTER: begin
                    if (!is_ws) begin
                        if (cur_depth == '0) begin
                            ok = 1'b0;
                        end else if (byte_value == ",") begin
                            ns = (top_kind == KIND_OBJECT) ? S_OBJ_KEY : S_VALUE;
                        end else if (top_kind == KIND_OBJECT && byte_value == "}") begin
                            pop = 1'b1;
                        end else if (top_kind == KIND_ARRAY && byte_value == "]") begin
                            pop = 1'b1;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                end
                default: ok = 1'b0;
            endcase
        end

        if (push) nd = cur_depth + DW'(1);
        if (pop)  nd = cur_depth - DW'(1);
    end

    always_comb begin
        nxt_state    = cur_state;
        nxt_lit      = cur_lit;
        nxt_depth    = cur_depth;
        nxt_rejected = cur_rejected;
        ctl          = '{push: 1'b0, pop: 1'b0, kind: kind};
        done         = 1'b0;
        status       = STATUS_REJECT;
        if (!cur_rejected) begin
            if (!ok) begin
                nxt_rejected = 1'b1;
            end else begin
                nxt_state = ns;
                nxt_lit   = nl;
                nxt_depth = nd;
                ctl.push  = push;
                ctl.pop   = pop;
                done = (nd == '0) && (ns == S_AFTER || ns == S_NUM_INT ||
                                      ns == S_NUM_FRAC || ns == S_NUM_EXP);
                if (!last) begin
                    status = STATUS_BUSY;
                end else if (done) begin
                    status = STATUS_VALID;
                end
            end
        end
    end

endmodule

// ===== rtl/core/json_syntax_validator_core.sv =====
// JSON syntax checker, one document byte per transfer.
//
// Input channel (s_valid/s_ready): s_byte_value is the next byte of a document,
// s_last marks its final byte. Output channel (m_valid/m_ready): one result per
// input byte, in order: m_status (0 in progress, 1 valid document at its last
// byte, 2 rejected now or earlier in this document), m_depth (container nesting
// after the byte) and m_position (byte index within the document, saturating).
// depth_limit_we/depth_limit_wdata write the nesting limit; write it only while
// no transfer is in flight.
//
// A byte accepted lands in the input register; once the output slot is free, its
// result is written into the output register and m_valid rises. Throughput is
// one byte per cycle unless the receiver stalls: the parse state, depth and
// the top of the kind stack all update in the single step between the registers.
// A stalled receiver holds the output register, which holds the input register;
// s_ready then drops until the result is taken, and no byte is lost.
// Reset clears both stages, the parse state and position, and sets the limit
// to 32. After a last byte, the next byte starts a new document at position 0.
module json_syntax_validator_core #(
    parameter int MAX_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [5:0]  m_depth,
    output logic [31:0] m_position,
    input  logic        depth_limit_we,
    input  logic [5:0]  depth_limit_wdata
);
    import jsv_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);

    // Input stage outputs
    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
    logic       fire;

    // Document state
    parse_state_t  state_reg;
    logic [2:0]    lit_reg;
    logic [DW-1:0] depth_reg;
    logic          rejected_reg;
    logic [31:0]   position_reg;
    logic [5:0]    limit_reg;

    // Step results
    parse_state_t  state_next;
    logic [2:0]    lit_next;
    logic [DW-1:0] depth_next;
    logic          rejected_next;
    status_t       status_next;
    stack_ctl_t    step_ctl;
    stack_ctl_t    stack_ctl;
    logic          top_kind;

    // Output register
    logic        m_valid_reg;
    logic [1:0]  status_reg;
    logic [5:0]  m_depth_reg;
    logic [31:0] m_position_reg;

    // Advance the byte held in the input stage when the output slot is free.
    assign fire = in_valid && (!m_valid_reg || m_ready);

    jsv_in_stage u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_value (s_byte_value),
        .s_last       (s_last),
        .advance      (fire),
        .in_valid     (in_valid),
        .in_byte      (in_byte),
        .in_last      (in_last)
    );

    jsv_step #(
        .MAX_DEPTH (MAX_DEPTH),
        .DW        (DW)
    ) u_step (
        .cur_state    (state_reg),
        .cur_lit      (lit_reg),
        .cur_depth    (depth_reg),
        .cur_rejected (rejected_reg),
        .top_kind     (top_kind),
        .byte_value   (in_byte),
        .last         (in_last),
        .depth_limit  (limit_reg),
        .nxt_state    (state_next),
        .nxt_lit      (lit_next),
        .nxt_depth    (depth_next),
        .nxt_rejected (rejected_next),
        .status       (status_next),
        .ctl          (step_ctl)
    );

    // Only touch the stack on a real transfer.
    always_comb begin
        stack_ctl      = step_ctl;
        stack_ctl.push = step_ctl.push && fire;
        stack_ctl.pop  = step_ctl.pop && fire;
    end

    jsv_kind_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .aclk     (aclk),
        .ctl      (stack_ctl),
        .top_kind (top_kind)
    );

    // Limit register: written directly, no handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= DEPTH_LIMIT_RESET;
        end else if (depth_limit_we) begin
            limit_reg <= depth_limit_wdata;
        end
    end

    // Document state: advance per byte, drop everything after a last byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_VALUE;
            lit_reg      <= 3'd0;
            depth_reg    <= '0;
            rejected_reg <= 1'b0;
            position_reg <= 32'd0;
        end else if (fire) begin
            if (in_last) begin
                state_reg    <= S_VALUE;
                lit_reg      <= 3'd0;
                depth_reg    <= '0;
                rejected_reg <= 1'b0;
                position_reg <= 32'd0;
            end else begin
                state_reg    <= state_next;
                lit_reg      <= lit_next;
                depth_reg    <= depth_next;
                rejected_reg <= rejected_next;
                if (position_reg != POSITION_MAX) begin
                    position_reg <= position_reg + 32'd1;
                end
            end
        end
    end

    // Output register: hold while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg     <= status_next;
            m_depth_reg    <= 6'(depth_next);
            m_position_reg <= position_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_depth    = m_depth_reg;
    assign m_position = m_position_reg;

    // Nesting never goes past the stack size.
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(depth_reg) <= 32'(MAX_DEPTH))
        else $error("nesting depth beyond stack size");

    // A document reported valid has all containers closed.
    a_valid_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_VALID |-> m_depth == 6'd0)
        else $error("valid status with open containers");

    // Rejection stays until the document ends.
    a_reject_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        rejected_reg && !(fire && in_last) |=> rejected_reg)
        else $error("rejection dropped inside a document");

    // A last byte restarts the position count and clears the depth.
    a_last_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last |=> position_reg == 32'd0 && depth_reg == '0)
        else $error("document state not cleared after last byte");

    // A held result keeps its payload while the receiver stalls.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position) && $stable(m_status))
        else $error("stalled result changed");

endmodule

// ===== tb/sv/jsv_result_checker.sv =====
`timescale 1ns / 1ps

module jsv_result_checker #(
    parameter int MAX_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [5:0]  m_depth,
    input  logic [31:0] m_position,
    input  logic        depth_limit_we,
    input  logic [5:0]  depth_limit_wdata,
    output int          mismatches,
    output int          outstanding,
    output int          checked,
    output int          docs_valid,
    output int          docs_rejected
);
    import jsv_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [5:0]  depth;
        logic [31:0] position;
    } byte_verdict_t;

    byte_verdict_t verdict_q [$];
    byte_verdict_t want;
    byte_verdict_t got;

    // Shadow parser state
    parse_state_t pst;
    logic [2:0]   lit_idx;
    logic         kinds [MAX_DEPTH];
    int unsigned  nest;
    logic [31:0]  byte_pos;
    logic         rejected;
    logic [5:0]   limit;

    int err_cnt;
    int checked_cnt;
    int valid_cnt;
    int reject_cnt;

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit esc_char(logic [7:0] c);
        return c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
               c == "n" || c == "r" || c == "t";
    endfunction

    function automatic void clear_doc();
        pst = S_VALUE;
        lit_idx = 3'd0;
        nest = 0;
        byte_pos = 32'd0;
        rejected = 1'b0;
    endfunction

    function automatic bit open_container(logic kind);
        int unsigned lim;
        lim = (limit < MAX_DEPTH) ? limit : MAX_DEPTH;
        if (nest >= lim) return 1'b0;
        kinds[nest] = kind;
        nest++;
        return 1'b1;
    endfunction

    function automatic bit start_value(logic [7:0] c);
        case (c)
            "\"": begin pst = S_STR; return 1'b1; end
            "{": begin
                if (!open_container(KIND_OBJECT)) return 1'b0;
                pst = S_OBJ_FIRST;
                return 1'b1;
            end
            "[": begin
                if (!open_container(KIND_ARRAY)) return 1'b0;
                pst = S_ARR_FIRST;
                return 1'b1;
            end
            "t": begin pst = S_LIT_T; lit_idx = 3'd1; return 1'b1; end
            "f": begin pst = S_LIT_F; lit_idx = 3'd1; return 1'b1; end
            "n": begin pst = S_LIT_N; lit_idx = 3'd1; return 1'b1; end
            "-": begin pst = S_NUM_MINUS; return 1'b1; end
            default: begin
                if (is_num(c)) begin
                    pst = S_NUM_INT;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Advance the shadow parser by one byte; 0 means the byte is rejected.
    function automatic bit consume(logic [7:0] c);
        string word;
        // Number states: a byte that cannot extend the number ends it and
        // is then treated as the byte after a value.
        case (pst)
            S_NUM_MINUS: begin
                if (!is_num(c)) return 1'b0;
                pst = S_NUM_INT;
                return 1'b1;
            end
            S_NUM_INT: begin
                if (is_num(c)) return 1'b1;
                if (c == ".") begin pst = S_NUM_DOT; return 1'b1; end
                if (c == "e" || c == "E") begin pst = S_NUM_E; return 1'b1; end
                pst = S_AFTER;
            end
            S_NUM_DOT: begin
                if (!is_num(c)) return 1'b0;
                pst = S_NUM_FRAC;
                return 1'b1;
            end
            S_NUM_FRAC: begin
                if (is_num(c)) return 1'b1;
                if (c == "e" || c == "E") begin pst = S_NUM_E; return 1'b1; end
                pst = S_AFTER;
            end
            S_NUM_E: begin
                if (c == "+" || c == "-") begin pst = S_NUM_ESIGN; return 1'b1; end
                if (!is_num(c)) return 1'b0;
                pst = S_NUM_EXP;
                return 1'b1;
            end
            S_NUM_ESIGN: begin
                if (!is_num(c)) return 1'b0;
                pst = S_NUM_EXP;
                return 1'b1;
            end
            S_NUM_EXP: begin
                if (is_num(c)) return 1'b1;
                pst = S_AFTER;
            end
            default: ;
        endcase

        case (pst)
            S_VALUE: begin
                if (is_space(c)) return 1'b1;
                return start_value(c);
            end
            S_ARR_FIRST: begin
                if (is_space(c)) return 1'b1;
                if (c == "]") begin nest--; pst = S_AFTER; return 1'b1; end
                return start_value(c);
            end
            S_OBJ_FIRST: begin
                if (is_space(c)) return 1'b1;
                if (c == "}") begin nest--; pst = S_AFTER; return 1'b1; end
                if (c == "\"") begin pst = S_KEY_STR; return 1'b1; end
                return 1'b0;
            end
            S_OBJ_KEY: begin
                if (is_space(c)) return 1'b1;
                if (c == "\"") begin pst = S_KEY_STR; return 1'b1; end
                return 1'b0;
            end
            S_KEY_STR: begin
                if (c == "\"") pst = S_COLON;
                else if (c == "\\") pst = S_KEY_ESC;
                return 1'b1;
            end
            S_KEY_ESC: begin
                if (!esc_char(c)) return 1'b0;
                pst = S_KEY_STR;
                return 1'b1;
            end
            S_COLON: begin
                if (is_space(c)) return 1'b1;
                if (c == ":") begin pst = S_VALUE; return 1'b1; end
                return 1'b0;
            end
            S_STR: begin
                if (c == "\"") pst = S_AFTER;
                else if (c == "\\") pst = S_STR_ESC;
                return 1'b1;
            end
            S_STR_ESC: begin
                if (!esc_char(c)) return 1'b0;
                pst = S_STR;
                return 1'b1;
            end
            S_LIT_T, S_LIT_F, S_LIT_N: begin
                word = (pst == S_LIT_T) ? "true" : (pst == S_LIT_F) ? "false" : "null";
                if (lit_idx >= word.len()) return 1'b0;
                if (c != 8'(word[lit_idx])) return 1'b0;
                lit_idx++;
                if (lit_idx == word.len()) begin
                    lit_idx = 3'd0;
                    pst = S_AFTER;
                end
                return 1'b1;
            end
            S_AFTER: begin
                if (is_space(c)) return 1'b1;
                if (nest == 0) return 1'b0;
                if (kinds[nest - 1] == KIND_OBJECT) begin
                    if (c == ",") begin pst = S_OBJ_KEY; return 1'b1; end
                    if (c == "}") begin nest--; return 1'b1; end
                end else begin
                    if (c == ",") begin pst = S_VALUE; return 1'b1; end
                    if (c == "]") begin nest--; return 1'b1; end
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            limit = DEPTH_LIMIT_RESET;
            clear_doc();
            verdict_q.delete();
            err_cnt = 0;
            checked_cnt = 0;
            valid_cnt = 0;
            reject_cnt = 0;
        end else begin
            if (depth_limit_we) limit = depth_limit_wdata;

            // Compare before predicting: a byte taken at this edge cannot
            // have its result out yet.
            if (m_valid && m_ready) begin
                got = {m_status, m_depth, m_position};
                if (verdict_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: result with nothing expected: status %0d depth %0d position %0d",
                                 $realtime, got.status, got.depth, got.position);
                end else begin
                    want = verdict_q.pop_front();
                    checked_cnt++;
                    if (got.status !== want.status || got.depth !== want.depth ||
                        got.position !== want.position) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"%0t: result %0d mismatch: expected status %0d depth %0d ",
                                      "position %0d, got status %0d depth %0d position %0d"},
                                     $realtime, checked_cnt, want.status, want.depth,
                                     want.position, got.status, got.depth, got.position);
                    end
                end
            end

            if (s_valid && s_ready) begin
                want.position = byte_pos;
                if (!rejected && !consume(s_byte_value)) rejected = 1'b1;
                if (rejected)
                    want.status = STATUS_REJECT;
                else if (s_last)
                    want.status = (nest == 0 && (pst == S_AFTER || pst == S_NUM_INT ||
                                  pst == S_NUM_FRAC || pst == S_NUM_EXP)) ?
                                  STATUS_VALID : STATUS_REJECT;
                else
                    want.status = STATUS_BUSY;
                want.depth = nest[5:0];
                verdict_q = {verdict_q, want};
                if (byte_pos != POSITION_MAX) byte_pos++;
                if (s_last) begin
                    if (want.status == STATUS_VALID) valid_cnt++;
                    else reject_cnt++;
                    clear_doc();
                end
            end
        end

        mismatches    <= err_cnt;
        outstanding   <= verdict_q.size();
        checked       <= checked_cnt;
        docs_valid    <= valid_cnt;
        docs_rejected <= reject_cnt;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import jsv_pkg::*;

    localparam int MAX_DEPTH      = 32;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_BYTES    = 75;
    localparam int HOLD_CYCLES    = 48;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = 8'h00;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [5:0]  m_depth;
    logic [31:0] m_position;
    logic        depth_limit_we = 1'b0;
    logic [5:0]  depth_limit_wdata = 6'd0;

    int mismatches;
    int outstanding;
    int checked;
    int docs_valid;
    int docs_rejected;

    // Per-phase plan: nesting limit (random in the last phase) and who idles. The first phase runs
    // without idling and carries the long receiver hold.
    int         limit_plan [NUM_PHASES] = '{32, 0, 1, 2, 63, 5, 32, 17};
    idle_mode_t mode_plan  [NUM_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                            IDLE_BOTH, IDLE_NONE, IDLE_RECEIVER,
                                            IDLE_SENDER, IDLE_BOTH};

    idle_mode_t idle_mode = IDLE_NONE;
    logic       hold_req = 1'b0;
    int         hold_left = HOLD_CYCLES;
    int         stall_cycles = 0;

    logic [7:0] doc_q [$];
    logic [7:0] ws_set [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    string      esc_set = "\"\\/bfnrt";
    int         bytes_sent = 0;
    int         docs_sent = 0;
    int         phase_bytes = 0;
    int         cur_limit = 32;

    json_syntax_validator_core #(
        .MAX_DEPTH(MAX_DEPTH)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_value      (s_byte_value),
        .s_last            (s_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_depth           (m_depth),
        .m_position        (m_position),
        .depth_limit_we    (depth_limit_we),
        .depth_limit_wdata (depth_limit_wdata)
    );

    jsv_result_checker #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_value      (s_byte_value),
        .s_last            (s_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_depth           (m_depth),
        .m_position        (m_position),
        .depth_limit_we    (depth_limit_we),
        .depth_limit_wdata (depth_limit_wdata),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .checked           (checked),
        .docs_valid        (docs_valid),
        .docs_rejected     (docs_rejected)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Receiver: hold off once for a long stretch when asked, otherwise
    // stall at random according to the current idle mode.
    always @(posedge aclk) begin : rx_side
        int stall_pct;
        stall_pct = (idle_mode == IDLE_RECEIVER) ? 78 : (idle_mode == IDLE_BOTH) ? 29 : 0;
        if (hold_req && hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: count cycles in which no transfer happens on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", stall_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one byte; insert a random gap first when the sender idles.
    // Return at the edge where the transfer happens, with valid still high.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 78 : (idle_mode == IDLE_BOTH) ? 29 : 0;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < gap_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_value <= b;
        s_last <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        phase_bytes++;
    endtask

    // Send the whole document buffer, marking its final byte.
    task automatic send_doc();
        for (int i = 0; i < doc_q.size(); i++)
            send_byte(doc_q[i], i == doc_q.size() - 1);
        docs_sent++;
    endtask

    // Append one byte to the document buffer.
    task automatic put_byte(input logic [7:0] b);
        doc_q = {doc_q, b};
    endtask

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++) put_byte(t[i]);
    endtask

    task automatic send_text(input string t);
        doc_q.delete();
        push_text(t);
        send_doc();
    endtask

    // Drop valid and wait until every expected result has come back. The
    // outstanding count is a registered copy, so step the clock before looking at it.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Write the nesting limit; only call while the block is idle.
    task automatic write_limit(input int v);
        depth_limit_we <= 1'b1;
        depth_limit_wdata <= 6'(v);
        @(posedge aclk);
        depth_limit_we <= 1'b0;
        cur_limit = v;
    endtask

    task automatic add_ws();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) put_byte(ws_set[$urandom_range(0, 5)]);
    endtask

    // String with escapes and raw bytes of any value but quote and backslash,
    // so every bit of the byte field toggles.
    task automatic add_string();
        logic [7:0] c;
        put_byte("\"");
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 4) == 0) begin
                put_byte("\\");
                put_byte(esc_set[$urandom_range(0, 7)]);
            end else begin
                do c = 8'($urandom_range(0, 255)); while (c == "\"" || c == "\\");
                put_byte(c);
            end
        end
        put_byte("\"");
    endtask

    task automatic add_number();
        if ($urandom_range(0, 2) == 0) put_byte("-");
        repeat ($urandom_range(1, 3)) put_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
            put_byte(".");
            repeat ($urandom_range(1, 2)) put_byte(8'("0" + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 2) == 0) begin
            put_byte($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                0: put_byte("+");
                1: put_byte("-");
                default: ;
            endcase
            repeat ($urandom_range(1, 2)) put_byte(8'("0" + $urandom_range(0, 9)));
        end
    endtask

    task automatic add_scalar();
        case ($urandom_range(0, 5))
            0: add_string();
            1, 2: add_number();
            3: push_text("true");
            4: push_text("false");
            default: push_text("null");
        endcase
    endtask

    task automatic add_key();
        add_string();
        add_ws();
        put_byte(":");
        add_ws();
    endtask

    // Build one well-formed document with random content, at most nest_cap
    // containers deep, without recursion: keep the open container kinds.
    task automatic build_json(input int nest_cap);
        logic open_kinds [$];
        logic is_obj;
        bit   need_value;
        doc_q.delete();
        need_value = 1'b1;
        add_ws();
        while (1) begin
            if (need_value) begin
                if (open_kinds.size() < nest_cap && doc_q.size() < 40 &&
                    $urandom_range(0, 2) == 0) begin
                    is_obj = 1'($urandom_range(0, 1));
                    put_byte(is_obj ? "{" : "[");
                    open_kinds = {open_kinds, is_obj};
                    add_ws();
                    if ($urandom_range(0, 4) == 0) begin
                        put_byte(is_obj ? "}" : "]");
                        void'(open_kinds.pop_back());
                        need_value = 1'b0;
                    end else if (is_obj) begin
                        add_key();
                    end
                end else begin
                    add_scalar();
                    need_value = 1'b0;
                end
            end else begin
                // Trailing whitespace may be empty so a top-level number can
                // end on the last byte.
                add_ws();
                if (open_kinds.size() == 0) break;
                if (doc_q.size() < 40 && $urandom_range(0, 1) == 0) begin
                    put_byte(",");
                    add_ws();
                    if (open_kinds[$]) add_key();
                    need_value = 1'b1;
                end else begin
                    put_byte(open_kinds[$] ? "}" : "]");
                    void'(open_kinds.pop_back());
                end
            end
        end
    endtask

    // Nest n containers around a single value, to hit the nesting limit.
    task automatic build_deep(input int n);
        logic deep_kinds [$];
        doc_q.delete();
        if (n < 1) n = 1;
        repeat (n) begin
            deep_kinds = {deep_kinds, 1'($urandom_range(0, 1))};
            if (deep_kinds[$]) push_text("{\"d\":");
            else put_byte("[");
        end
        put_byte("1");
        while (deep_kinds.size() != 0)
            put_byte(deep_kinds.pop_back() ? "}" : "]");
    endtask

    // Mangle a well-formed document, which need not break it: corrupt a byte, cut
    // it short, or append a second value or a stray comma.
    task automatic mangle_doc();
        case ($urandom_range(0, 3))
            0: doc_q[$urandom_range(0, doc_q.size() - 1)] = 8'($urandom_range(0, 255));
            1: if (doc_q.size() > 1) doc_q = doc_q[0:$urandom_range(0, doc_q.size() - 2)];
            2: begin
                add_ws();
                add_scalar();
            end
            default: begin
                add_ws();
                put_byte(",");
            end
        endcase
    endtask

    initial begin
        int eff;
        int pick;
        int lim;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: literal, number ended by a closing bracket, sticky reject
        // on an unknown escape, escaped key, whitespace only (incomplete),
        // the lowest and highest byte values, number ending on the last byte.
        send_text("true");
        send_text("[5]");
        send_text("\"\\u\"");
        send_text("{\"\\t\":1}");
        send_text(" ");
        doc_q = '{8'h00, 8'hFF};
        send_doc();
        send_text("-1e5");
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            lim = (ph == NUM_PHASES - 1) ? $urandom_range(0, 63) : limit_plan[ph];
            write_limit(lim);
            idle_mode <= mode_plan[ph];
            // First phase: the receiver holds off while bytes keep coming.
            if (ph == 0) hold_req <= 1'b1;
            eff = (cur_limit > MAX_DEPTH) ? MAX_DEPTH : cur_limit;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    build_json(eff < 4 ? eff : 4);
                end else if (pick < 65) begin
                    build_deep(eff + $urandom_range(0, 1));
                end else if (pick < 88) begin
                    build_json(eff < 3 ? eff : 3);
                    mangle_doc();
                end else if (pick < 95) begin
                    doc_q.delete();
                    repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
                end else begin
                    doc_q.delete();
                    repeat ($urandom_range(1, 3)) put_byte(ws_set[$urandom_range(0, 5)]);
                end
                send_doc();
            end
            drain();
        end

        // Let any stray result show up before the verdict.
        repeat (4) @(posedge aclk);
        $display("Sent %0d bytes in %0d documents over %0d nesting limits; %0d results checked",
                 bytes_sent, docs_sent, NUM_PHASES + 1, checked);
        $display("Documents ending well-formed: %0d, rejected: %0d; mismatches: %0d",
                 docs_valid, docs_rejected, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
